// ===== src/nfa_pkg.sv =====
`timescale 1ns / 1ps

package nfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int OFF_W     = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_DOUBLE    = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic [5:0] RESERVED_ID   = 6'd0;
  localparam logic [5:0] FIRST_USER_ID = 6'd1;

  typedef struct packed {
    logic start;
    logic advance;
    logic fin_alloc;
    logic fin_free;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } dp_sts_t;

endpackage

// ===== src/nfa_ctrl.sv =====
`timescale 1ns / 1ps

module nfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  output logic              out_valid,
  input  logic              out_ready,
  input  nfa_pkg::dp_sts_t  sts,
  output nfa_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = (in_command == nfa_pkg::CMD_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.last) begin
          // hold the verdict until the output register can take it
          if (slot_free) begin
            cmd.fin_alloc = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FREE: begin
        if (slot_free) begin
          cmd.fin_free = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.fin_alloc || cmd.fin_free || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/nfa_datapath.sv =====
`timescale 1ns / 1ps

module nfa_datapath #(
  parameter int NUM_IDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_command,
  input  logic [5:0]        in_target_id,
  input  nfa_pkg::ctl_cmd_t cmd,
  output nfa_pkg::dp_sts_t  sts,
  output logic [2:0]        out_status,
  output logic [5:0]        out_result_id
);

  localparam int IDW  = $clog2(NUM_IDS);
  localparam int NW   = (NUM_IDS + nfa_pkg::WORD_BITS - 1) / nfa_pkg::WORD_BITS;
  localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int CW   = ((IDW > 6) ? IDW : 6) + 1;
  localparam int TAIL = NUM_IDS % nfa_pkg::WORD_BITS;
  localparam logic [31:0]     LAST_MASK = (TAIL == 0) ? {32{1'b1}} :
                                          ((32'd1 << TAIL) - 32'd1);
  localparam logic [WAW-1:0]  LAST_ADDR = WAW'(NW - 1);
  localparam logic [CNTW-1:0] NW_CNT    = CNTW'(NW);

  logic [31:0]      words_r [NW];
  logic [IDW-1:0]   hint_r, hint_nxt;
  logic [WAW-1:0]   addr_r, addr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [5:0]       tgt_r;
  logic [2:0]       status_r, status_nxt;
  logic [5:0]       rid_r, rid_nxt;

  logic [31:0]      rd_word, lo_mask, range_m, valid_m, free_bits, word_nxt;
  logic             wr_en, hit, tgt_ok, tgt_bit;
  logic [4:0]       bitpos;
  logic [IDW-1:0]   found_id, tgt_id, hint_after_alloc;
  logic [IDW:0]     found_inc;
  logic [WAW-1:0]   tgt_word;

  assign rd_word = words_r[addr_r];
  assign lo_mask = {32{1'b1}} << hint_r[nfa_pkg::OFF_W-1:0];

  // first word from the hint upward, whole words after, and the hint word
  // again below the hint on the wrap-around visit
  always_comb begin
    if (cnt_r == '0) begin
      range_m = lo_mask;
    end else if (cnt_r == NW_CNT) begin
      range_m = ~lo_mask;
    end else begin
      range_m = {32{1'b1}};
    end
  end

  assign valid_m   = (addr_r == LAST_ADDR) ? LAST_MASK : {32{1'b1}};
  assign free_bits = ~rd_word & range_m & valid_m;

  always_comb begin
    hit    = 1'b0;
    bitpos = '0;
    for (int i = nfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit    = 1'b1;
        bitpos = 5'(i);
      end
    end
  end

  assign sts.hit  = hit;
  assign sts.last = (cnt_r == NW_CNT);

  assign found_id         = IDW'({addr_r, bitpos});
  assign found_inc        = {1'b0, found_id} + (IDW+1)'(1);
  assign hint_after_alloc = (found_inc < (IDW+1)'(NUM_IDS)) ? IDW'(found_inc) :
                            IDW'(nfa_pkg::FIRST_USER_ID);

  assign tgt_ok  = (tgt_r != nfa_pkg::RESERVED_ID) && (CW'(tgt_r) < CW'(NUM_IDS));
  assign tgt_id  = IDW'(tgt_r);
  assign tgt_bit = rd_word[tgt_r[4:0]];

  assign tgt_word = (CW'(in_target_id) < CW'(NUM_IDS)) ? WAW'(in_target_id >> 5) : '0;

  always_comb begin
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    hint_nxt   = hint_r;
    wr_en      = 1'b0;
    word_nxt   = rd_word;
    status_nxt = status_r;
    rid_nxt    = rid_r;
    if (cmd.start) begin
      addr_nxt = (in_command == nfa_pkg::CMD_FREE) ? tgt_word : WAW'(hint_r >> 5);
      cnt_nxt  = '0;
    end
    if (cmd.advance) begin
      addr_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + WAW'(1);
      cnt_nxt  = cnt_r + CNTW'(1);
    end
    if (cmd.fin_alloc) begin
      if (hit) begin
        wr_en      = 1'b1;
        word_nxt   = rd_word | (32'd1 << bitpos);
        hint_nxt   = hint_after_alloc;
        status_nxt = nfa_pkg::ST_ALLOCATED;
        rid_nxt    = 6'(found_id);
      end else begin
        status_nxt = nfa_pkg::ST_EXHAUSTED;
        rid_nxt    = '0;
      end
    end
    if (cmd.fin_free) begin
      if (!tgt_ok) begin
        status_nxt = nfa_pkg::ST_IGNORED;
        rid_nxt    = '0;
      end else if (!tgt_bit) begin
        status_nxt = nfa_pkg::ST_DOUBLE;
        rid_nxt    = '0;
      end else begin
        wr_en      = 1'b1;
        word_nxt   = rd_word & ~(32'd1 << tgt_r[4:0]);
        status_nxt = nfa_pkg::ST_FREED;
        rid_nxt    = tgt_r;
        if (tgt_id < hint_r) begin
          hint_nxt = tgt_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // ID 0 starts out taken
      for (int w = 0; w < NW; w++) begin
        words_r[w] <= (w == 0) ? 32'd1 : 32'd0;
      end
      hint_r <= IDW'(nfa_pkg::FIRST_USER_ID);
    end else begin
      if (wr_en) begin
        words_r[addr_r] <= word_nxt;
      end
      hint_r <= hint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    if (cmd.start) begin
      tgt_r <= in_target_id;
    end
  end

  assign out_status    = status_r;
  assign out_result_id = rid_r;

endmodule

// ===== src/next_fit_bitmap_id_allocator.sv =====
`timescale 1ns / 1ps
// An allocate scans the 32-bit map words one by one from the hint's word, k of them,
// 1 to NW + 1 with NW = NUM_IDS/32 rounded up (1 to 3 at 64 IDs), the hint word again
// on the wrap; a free reads only its target's word. One transaction is in flight at a
// time; the next is accepted as soon as the result sits in the output register, and a
// result held by out_ready stalls the next one at the end of its scan or free.
// Synchronous reset: ID 0 marked used, all others free, hint at 1.
module next_fit_bitmap_id_allocator #(
  parameter int NUM_IDS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [5:0] in_target_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [5:0] out_result_id
);

  nfa_pkg::ctl_cmd_t cmd;
  nfa_pkg::dp_sts_t  sts;

  nfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nfa_datapath #(
    .NUM_IDS (NUM_IDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_target_id  (in_target_id),
    .cmd           (cmd),
    .sts           (sts),
    .out_status    (out_status),
    .out_result_id (out_result_id)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.advance, cmd.fin_alloc, cmd.fin_free}))
    else $error("controller issued more than one command");

  a_alloc_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_alloc |-> (sts.hit || sts.last))
    else $error("allocate finished before the scan reached a verdict");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_no_id_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == nfa_pkg::ST_EXHAUSTED || out_status == nfa_pkg::ST_DOUBLE
     || out_status == nfa_pkg::ST_IGNORED)) |-> (out_result_id == 6'd0))
    else $error("non-zero ID reported with a failing status");
`endif

endmodule

// ===== dv/nfa_grant_checker.sv =====
`timescale 1ns / 1ps

module nfa_grant_checker #(
  parameter int NUM_IDS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_command,
  input  logic [5:0] in_target_id,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_status,
  input  logic [5:0] out_result_id,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         exhausted_seen,
  output int         double_seen,
  output int         ignored_seen
);

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] id;
  } id_reply_t;

  logic [NUM_IDS-1:0] id_busy;
  int                 next_hint;
  id_reply_t          pending_grants[$];

  function automatic id_reply_t predict_grant(input logic cmd, input logic [5:0] tgt);
    id_reply_t reply;
    int        found;
    int        i;
    reply.status = nfa_pkg::ST_EXHAUSTED;
    reply.id     = '0;
    found        = -1;
    if (cmd == nfa_pkg::CMD_ALLOC) begin
      // upper pass from the hint, then wrap to the first user ID
      for (i = next_hint; i < NUM_IDS && found < 0; i++)
        if (!id_busy[i]) found = i;
      for (i = int'(nfa_pkg::FIRST_USER_ID); i < next_hint && found < 0; i++)
        if (!id_busy[i]) found = i;
      if (found >= 0) begin
        id_busy[found] = 1'b1;
        next_hint      = (found + 1 < NUM_IDS) ? found + 1 : int'(nfa_pkg::FIRST_USER_ID);
        reply.status   = nfa_pkg::ST_ALLOCATED;
        reply.id       = found[5:0];
      end
    end else if (tgt == nfa_pkg::RESERVED_ID || int'(tgt) >= NUM_IDS) begin
      reply.status = nfa_pkg::ST_IGNORED;
    end else if (!id_busy[tgt]) begin
      reply.status = nfa_pkg::ST_DOUBLE;
    end else begin
      id_busy[tgt] = 1'b0;
      if (int'(tgt) < next_hint) next_hint = int'(tgt);
      reply.status = nfa_pkg::ST_FREED;
      reply.id     = tgt;
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    id_reply_t want;
    if (!rst_n) begin
      id_busy                       = '0;
      id_busy[nfa_pkg::RESERVED_ID] = 1'b1;
      next_hint                     = int'(nfa_pkg::FIRST_USER_ID);
      pending_grants.delete();
      fail_count          = 0;
      checked             = 0;
      exhausted_seen      = 0;
      double_seen         = 0;
      ignored_seen        = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d id %0d",
                   $time, out_status, out_result_id);
          fail_count++;
        end else begin
          want = pending_grants.pop_front();
          checked++;
          if (out_status != want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
          if (out_result_id != want.id) begin
            $display("%0t: result_id mismatch: expected %0d, actual %0d",
                     $time, want.id, out_result_id);
            fail_count++;
          end
          if (want.status == nfa_pkg::ST_EXHAUSTED) exhausted_seen++;
          if (want.status == nfa_pkg::ST_DOUBLE)    double_seen++;
          if (want.status == nfa_pkg::ST_IGNORED)   ignored_seen++;
        end
      end
      if (in_valid && in_ready)
        pending_grants.push_back(predict_grant(in_command, in_target_id));
    end
    pending = pending_grants.size();
  end

endmodule

// ===== dv/tb_next_fit_bitmap_id_allocator.sv =====
`timescale 1ns / 1ps

module tb_next_fit_bitmap_id_allocator;

  localparam int NUM_IDS     = 64;
  localparam int RANDOM_TXNS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_command;
  logic [5:0] in_target_id;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_status;
  logic [5:0] out_result_id;

  int fail_count;
  int pending;
  int checked;
  int exhausted_seen;
  int double_seen;
  int ignored_seen;

  int send_idle   = 0;
  int recv_idle   = 0;
  int sent        = 0;
  int alloc_sent  = 0;
  int free_sent   = 0;
  int cycle_count = 0;

  next_fit_bitmap_id_allocator #(.NUM_IDS(NUM_IDS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_target_id (in_target_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_result_id(out_result_id)
  );

  nfa_grant_checker #(.NUM_IDS(NUM_IDS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_target_id  (in_target_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .exhausted_seen(exhausted_seen),
    .double_seen   (double_seen),
    .ignored_seen  (ignored_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending);
      $display("next_fit_bitmap_id_allocator regression: fail");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle);

  // Hold the transaction until the block takes it; idle first at the sender's rate.
  task automatic drive_txn(input logic cmd, input logic [5:0] tgt);
    if (sent < 450) begin
      send_idle = 36;
      recv_idle = 49;
    end else if (sent < 900) begin
      send_idle = 49;
      recv_idle = 36;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_target_id <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (cmd == nfa_pkg::CMD_ALLOC) alloc_sent++;
    else                           free_sent++;
  endtask

  initial begin
    logic       alloc_heavy;
    int         seg_left;
    int         n;
    logic       cmd;
    logic [5:0] tgt;

    in_valid     <= 1'b0;
    in_command   <= nfa_pkg::CMD_ALLOC;
    in_target_id <= '0;
    rst_n        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    drive_txn(nfa_pkg::CMD_ALLOC, 6'd0);
    drive_txn(nfa_pkg::CMD_ALLOC, 6'd63);                 // target ignored on allocate
    drive_txn(nfa_pkg::CMD_FREE,  nfa_pkg::RESERVED_ID);   // reserved ID
    drive_txn(nfa_pkg::CMD_FREE,  6'd63);                 // never granted
    drive_txn(nfa_pkg::CMD_FREE,  nfa_pkg::FIRST_USER_ID); // hint drops back to 1
    drive_txn(nfa_pkg::CMD_ALLOC, 6'h2a);
    drive_txn(nfa_pkg::CMD_ALLOC, 6'h15);
    drive_txn(nfa_pkg::CMD_FREE,  6'd2);
    drive_txn(nfa_pkg::CMD_FREE,  6'd2);
    drive_txn(nfa_pkg::CMD_ALLOC, 6'h3f);
    drive_txn(nfa_pkg::CMD_FREE,  6'd3);
    drive_txn(nfa_pkg::CMD_FREE,  nfa_pkg::FIRST_USER_ID);
    drive_txn(nfa_pkg::CMD_ALLOC, 6'd0);
    drive_txn(nfa_pkg::CMD_FREE,  6'd0);

    // Alternate allocate-heavy and free-heavy stretches so the map fills,
    // runs dry, wraps the hint and drains again.
    alloc_heavy = 1'b0;
    seg_left    = 0;
    for (n = 0; n < RANDOM_TXNS; n++) begin
      if (seg_left == 0) begin
        seg_left    = $urandom_range(30, 120);
        alloc_heavy = !alloc_heavy;
      end
      seg_left--;
      cmd = ($urandom_range(0, 99) < (alloc_heavy ? 85 : 20)) ? nfa_pkg::CMD_ALLOC :
                                                                nfa_pkg::CMD_FREE;
      if (cmd == nfa_pkg::CMD_FREE && $urandom_range(0, 19) == 0)
        tgt = nfa_pkg::RESERVED_ID;
      else if (cmd == nfa_pkg::CMD_FREE)
        tgt = 6'($urandom_range(1, 63));
      else
        tgt = 6'($urandom_range(0, 63));
      drive_txn(cmd, tgt);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d allocates, %0d frees.",
             sent, alloc_sent, free_sent);
    $display("Checked %0d results: %0d exhausted, %0d double frees, %0d reserved frees.",
             checked, exhausted_seen, double_seen, ignored_seen);
    if (fail_count == 0) begin
      $display("next_fit_bitmap_id_allocator regression: pass");
    end else begin
      $display("next_fit_bitmap_id_allocator regression: fail");
    end
    $finish;
  end

endmodule
